@@ rtl/ssme_pkg.sv @@
// Shared types and constants for the scored slot store.
// Used by the controller, the datapath and the top level; depends on nothing.
package ssme_pkg;

  localparam int CAPACITY = 16;
  localparam int DIM      = 64;
  localparam int SLOT_W   = 4;
  localparam int ELEM_W   = 6;
  localparam int CNT_W    = 5;
  localparam int WORD_W   = 32;
  localparam int FACT_W   = 17;

  localparam logic [2:0] OP_WRITE     = 3'd0;
  localparam logic [2:0] OP_SET_SCORE = 3'd1;
  localparam logic [2:0] OP_DECAY_S   = 3'd2;
  localparam logic [2:0] OP_SET_ASSOC = 3'd3;
  localparam logic [2:0] OP_DECAY_A   = 3'd4;
  localparam logic [2:0] OP_READ      = 3'd5;
  localparam logic [2:0] OP_CLEAR     = 3'd6;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_RANGE  = 2'd1;
  localparam logic [1:0] ST_STREAM = 2'd2;

  localparam logic [3:0] A_NONE     = 4'd0;
  localparam logic [3:0] A_ACCEPT   = 4'd1;
  localparam logic [3:0] A_EV_RD    = 4'd2;
  localparam logic [3:0] A_EV_CMP   = 4'd3;
  localparam logic [3:0] A_EV_SHIFT = 4'd4;
  localparam logic [3:0] A_CP_RD    = 4'd5;
  localparam logic [3:0] A_CP_WR    = 4'd6;
  localparam logic [3:0] A_ZERO_ROW = 4'd7;
  localparam logic [3:0] A_ZERO_COL = 4'd8;
  localparam logic [3:0] A_INS_DONE = 4'd9;
  localparam logic [3:0] A_RD_DONE  = 4'd10;
  localparam logic [3:0] A_DS_RD    = 4'd11;
  localparam logic [3:0] A_DS_WR    = 4'd12;
  localparam logic [3:0] A_DA_RD    = 4'd13;
  localparam logic [3:0] A_DA_WR    = 4'd14;
  localparam logic [3:0] A_MUL_S    = 4'd15;

  typedef struct packed {
    logic [3:0]        act;
    logic              mul_assoc;
    logic [SLOT_W-1:0] i;
    logic [ELEM_W-1:0] j;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             insert_go;
    logic             full;
    logic             read_go;
    logic             decay_s_go;
    logic             decay_a_go;
  } stat_t;

endpackage

@@ rtl/ssme_ctrl.sv @@
// Sequencer for the scored slot store: walks eviction search, slot copy,
// association clearing and decay sweeps. Depends on ssme_pkg.
module ssme_ctrl import ssme_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  busy
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_EV_RD    = 4'd1;
  localparam logic [3:0] S_EV_CMP   = 4'd2;
  localparam logic [3:0] S_EV_SHIFT = 4'd3;
  localparam logic [3:0] S_CP_RD    = 4'd4;
  localparam logic [3:0] S_CP_WR    = 4'd5;
  localparam logic [3:0] S_ZR       = 4'd6;
  localparam logic [3:0] S_ZC       = 4'd7;
  localparam logic [3:0] S_INS_DONE = 4'd8;
  localparam logic [3:0] S_RD_DONE  = 4'd9;
  localparam logic [3:0] S_DS_RD    = 4'd10;
  localparam logic [3:0] S_DS_MUL   = 4'd11;
  localparam logic [3:0] S_DS_WR    = 4'd12;
  localparam logic [3:0] S_DA_RD    = 4'd13;
  localparam logic [3:0] S_DA_MUL   = 4'd14;
  localparam logic [3:0] S_DA_WR    = 4'd15;

  logic [3:0]        state, state_next;
  logic [SLOT_W-1:0] i, i_next;
  logic [ELEM_W-1:0] j, j_next;
  logic [CNT_W-1:0]  last_cnt;
  logic              i_last, j_last_cnt;
  logic              d_done;

  assign last_cnt   = stat.count - CNT_W'(1);
  assign i_last     = CNT_W'(i) == last_cnt;
  assign j_last_cnt = j == ELEM_W'(last_cnt);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      i      <= '0;
      j      <= '0;
      d_done <= 1'b0;
    end else begin
      state  <= state_next;
      i      <= i_next;
      j      <= j_next;
      d_done <= ((state == S_DS_WR) && i_last) ||
                ((state == S_DA_WR) && i_last && j_last_cnt);
    end
  end

  always_comb begin
    state_next = state;
    i_next     = i;
    j_next     = j;
    case (state)
      S_IDLE: begin
        if (start) begin
          i_next = '0;
          j_next = '0;
          if (stat.insert_go) state_next = stat.full ? S_EV_RD : S_CP_RD;
          else if (stat.read_go) state_next = S_RD_DONE;
          else if (stat.decay_s_go) state_next = S_DS_RD;
          else if (stat.decay_a_go) state_next = S_DA_RD;
        end
      end
      S_EV_RD: state_next = S_EV_CMP;
      S_EV_CMP: begin
        if (i == SLOT_W'(CAPACITY - 1)) state_next = S_EV_SHIFT;
        else begin
          i_next     = i + SLOT_W'(1);
          state_next = S_EV_RD;
        end
      end
      S_EV_SHIFT: begin
        j_next     = '0;
        state_next = S_CP_RD;
      end
      S_CP_RD: state_next = S_CP_WR;
      S_CP_WR: begin
        if (j == ELEM_W'(DIM - 1)) begin
          j_next     = '0;
          state_next = S_ZR;
        end else begin
          j_next     = j + ELEM_W'(1);
          state_next = S_CP_RD;
        end
      end
      S_ZR: state_next = S_ZC;
      S_ZC: begin
        if (j == ELEM_W'(CAPACITY - 1)) state_next = S_INS_DONE;
        else begin
          j_next     = j + ELEM_W'(1);
          state_next = S_ZR;
        end
      end
      S_INS_DONE: state_next = S_IDLE;
      S_RD_DONE:  state_next = S_IDLE;
      S_DS_RD:    state_next = S_DS_MUL;
      S_DS_MUL:   state_next = S_DS_WR;
      S_DS_WR: begin
        if (i_last) state_next = S_IDLE;
        else begin
          i_next     = i + SLOT_W'(1);
          state_next = S_DS_RD;
        end
      end
      S_DA_RD:  state_next = S_DA_MUL;
      S_DA_MUL: state_next = S_DA_WR;
      S_DA_WR: begin
        state_next = S_DA_RD;
        if (j_last_cnt) begin
          j_next = '0;
          if (i_last) state_next = S_IDLE;
          else i_next = i + SLOT_W'(1);
        end else begin
          j_next = j + ELEM_W'(1);
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // A decay sweep reports its result in the idle cycle that follows it.
  always_comb begin
    cmd.i         = i;
    cmd.j         = j;
    cmd.mul_assoc = (state == S_DA_MUL);
    case (state)
      S_IDLE:     cmd.act = start ? A_ACCEPT : A_NONE;
      S_EV_RD:    cmd.act = A_EV_RD;
      S_EV_CMP:   cmd.act = A_EV_CMP;
      S_EV_SHIFT: cmd.act = A_EV_SHIFT;
      S_CP_RD:    cmd.act = A_CP_RD;
      S_CP_WR:    cmd.act = A_CP_WR;
      S_ZR:       cmd.act = A_ZERO_ROW;
      S_ZC:       cmd.act = A_ZERO_COL;
      S_INS_DONE: cmd.act = A_INS_DONE;
      S_RD_DONE:  cmd.act = A_RD_DONE;
      S_DS_RD:    cmd.act = A_DS_RD;
      S_DS_MUL:   cmd.act = A_MUL_S;
      S_DS_WR:    cmd.act = A_DS_WR;
      S_DA_RD:    cmd.act = A_DA_RD;
      S_DA_MUL:   cmd.act = A_MUL_S;
      S_DA_WR:    cmd.act = A_DA_WR;
      default:    cmd.act = A_NONE;
    endcase
  end

  // Hold off new requests until the decay result has gone out as well.
  assign busy = (state != S_IDLE) || d_done;

endmodule

@@ rtl/ssme_dpath.sv @@
// Datapath of the scored slot store: memories, order map, count, decay
// multiplier and result registers. Depends on ssme_pkg.
module ssme_dpath import ssme_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  cmd_t                     cmd,
  input  logic                     d_fin,
  input  logic [2:0]               operation,
  input  logic [SLOT_W-1:0]        slot_index,
  input  logic [SLOT_W-1:0]        other_index,
  input  logic [ELEM_W-1:0]        element_index,
  input  logic [WORD_W-1:0]        key_word,
  input  logic [WORD_W-1:0]        value_word,
  input  logic                     last_element,
  input  logic signed [WORD_W-1:0] amount,
  input  logic [FACT_W-1:0]        decay_factor,
  output stat_t                    stat,
  output logic                     done,
  output logic [WORD_W-1:0]        key_out,
  output logic [WORD_W-1:0]        value_out,
  output logic signed [WORD_W-1:0] score_out,
  output logic signed [WORD_W-1:0] association_out,
  output logic [CNT_W-1:0]         slot_count,
  output logic                     evicted,
  output logic [SLOT_W-1:0]        evicted_position,
  output logic [1:0]               status
);

  localparam int SADDR_W = SLOT_W + ELEM_W;
  localparam int AADDR_W = 2 * SLOT_W;
  localparam int PROD_W  = WORD_W + FACT_W + 1;
  localparam int Q_W     = PROD_W - 16;

  logic [WORD_W-1:0] stg_key [DIM];
  logic [WORD_W-1:0] stg_val [DIM];
  logic [WORD_W-1:0] key_mem [CAPACITY*DIM];
  logic [WORD_W-1:0] val_mem [CAPACITY*DIM];
  logic [WORD_W-1:0] sc_mem  [CAPACITY];
  logic [WORD_W-1:0] as_mem  [CAPACITY*CAPACITY];

  logic [SLOT_W-1:0] order [CAPACITY];
  logic [CNT_W-1:0]  count;
  logic [ELEM_W-1:0] next_element;

  logic [WORD_W-1:0] stg_key_rd, stg_val_rd, key_rd, val_rd, sc_rd, as_rd;
  logic signed [WORD_W-1:0] best;
  logic [SLOT_W-1:0] best_pos;
  logic              ev_q;
  logic [SLOT_W-1:0] ev_pos_q;
  logic [FACT_W-1:0] factor_q;
  logic signed [PROD_W-1:0] prod;

  logic              accept, stream_ok, si_ok, oi_ok, long_op;
  logic [1:0]        st_code;
  logic [SLOT_W-1:0] ins_phys, phys_i, phys_j, phys_si, phys_oi;
  logic [SLOT_W-1:0] jj;
  logic [SLOT_W-1:0] sc_addr;
  logic              sc_we;
  logic [WORD_W-1:0] sc_wdata;
  logic [AADDR_W-1:0] as_addr;
  logic              as_we;
  logic [WORD_W-1:0] as_wdata;
  logic signed [PROD_W-1:0] adj;
  logic signed [Q_W-1:0]    q;
  logic [WORD_W-1:0] sat;

  assign accept   = cmd.act == A_ACCEPT;
  assign jj       = cmd.j[SLOT_W-1:0];
  assign ins_phys = order[count[SLOT_W-1:0]];
  assign phys_i   = order[cmd.i];
  assign phys_j   = order[jj];
  assign phys_si  = order[slot_index];
  assign phys_oi  = order[other_index];

  assign stream_ok = (element_index == next_element) &&
                     (last_element == (element_index == ELEM_W'(DIM - 1)));
  assign si_ok = CNT_W'(slot_index) < count;
  assign oi_ok = CNT_W'(other_index) < count;

  assign stat.count      = count;
  assign stat.full       = count == CNT_W'(CAPACITY);
  assign stat.insert_go  = (operation == OP_WRITE) && stream_ok && last_element;
  assign stat.read_go    = (operation == OP_READ) && si_ok && oi_ok;
  assign stat.decay_s_go = (operation == OP_DECAY_S) && (count != '0);
  assign stat.decay_a_go = (operation == OP_DECAY_A) && (count != '0);
  assign long_op = stat.insert_go || stat.read_go || stat.decay_s_go || stat.decay_a_go;

  always_comb begin
    st_code = ST_OK;
    case (operation)
      OP_WRITE:     if (!stream_ok) st_code = ST_STREAM;
      OP_SET_SCORE: if (!si_ok) st_code = ST_RANGE;
      OP_SET_ASSOC: if (!(si_ok && oi_ok)) st_code = ST_RANGE;
      OP_READ:      if (!(si_ok && oi_ok)) st_code = ST_RANGE;
      default:      st_code = ST_OK;
    endcase
  end

  // Truncate toward zero, then clamp to the signed word range.
  assign adj = prod + (prod[PROD_W-1] ? PROD_W'(65535) : PROD_W'(0));
  assign q   = Q_W'(adj >>> 16);
  always_comb begin
    if (q > Q_W'(32'sh7fffffff)) sat = 32'h7fffffff;
    else if (q < -Q_W'(33'sh080000000)) sat = 32'h80000000;
    else sat = q[WORD_W-1:0];
  end

  always_comb begin
    sc_addr  = phys_si;
    sc_we    = 1'b0;
    sc_wdata = amount;
    case (cmd.act)
      A_ACCEPT: sc_we = (operation == OP_SET_SCORE) && si_ok;
      A_EV_RD, A_DS_RD: sc_addr = phys_i;
      A_DS_WR: begin
        sc_addr  = phys_i;
        sc_we    = 1'b1;
        sc_wdata = sat;
      end
      A_INS_DONE: begin
        sc_addr  = ins_phys;
        sc_we    = 1'b1;
        sc_wdata = '0;
      end
      default: sc_addr = phys_si;
    endcase
  end

  always_comb begin
    as_addr  = {phys_si, phys_oi};
    as_we    = 1'b0;
    as_wdata = amount;
    case (cmd.act)
      A_ACCEPT: as_we = (operation == OP_SET_ASSOC) && si_ok && oi_ok;
      A_DA_RD:  as_addr = {phys_i, phys_j};
      A_DA_WR: begin
        as_addr  = {phys_i, phys_j};
        as_we    = 1'b1;
        as_wdata = sat;
      end
      A_ZERO_ROW: begin
        as_addr  = {ins_phys, jj};
        as_we    = 1'b1;
        as_wdata = '0;
      end
      A_ZERO_COL: begin
        as_addr  = {jj, ins_phys};
        as_we    = 1'b1;
        as_wdata = '0;
      end
      default: as_addr = {phys_si, phys_oi};
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept && (operation == OP_WRITE) && stream_ok) begin
      stg_key[element_index] <= key_word;
      stg_val[element_index] <= value_word;
    end
    stg_key_rd <= stg_key[cmd.j];
    stg_val_rd <= stg_val[cmd.j];
  end

  always_ff @(posedge clk) begin
    if (cmd.act == A_CP_WR) begin
      key_mem[SADDR_W'({ins_phys, cmd.j})] <= stg_key_rd;
      val_mem[SADDR_W'({ins_phys, cmd.j})] <= stg_val_rd;
    end
    key_rd <= key_mem[SADDR_W'({phys_si, element_index})];
    val_rd <= val_mem[SADDR_W'({phys_si, element_index})];
  end

  always_ff @(posedge clk) begin
    if (sc_we) sc_mem[sc_addr] <= sc_wdata;
    sc_rd <= sc_mem[sc_addr];
  end

  always_ff @(posedge clk) begin
    if (as_we) as_mem[as_addr] <= as_wdata;
    as_rd <= as_mem[as_addr];
  end

  // Working registers of the search and decay sweeps.
  always_ff @(posedge clk) begin
    if (accept) begin
      factor_q <= decay_factor;
      ev_q     <= 1'b0;
      ev_pos_q <= '0;
    end
    if (cmd.act == A_EV_CMP) begin
      if ((cmd.i == '0) || ($signed(sc_rd) < best)) begin
        best     <= $signed(sc_rd);
        best_pos <= cmd.i;
      end
    end
    if (cmd.act == A_EV_SHIFT) begin
      ev_q     <= 1'b1;
      ev_pos_q <= best_pos;
    end
    if (cmd.act == A_MUL_S) begin
      prod <= $signed(cmd.mul_assoc ? as_rd : sc_rd) * $signed({1'b0, factor_q});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      next_element <= '0;
      done         <= 1'b0;
      for (int k = 0; k < CAPACITY; k++) order[k] <= SLOT_W'(k);
    end else begin
      case (cmd.act)
        A_ACCEPT: begin
          done <= !long_op;
          if (operation == OP_WRITE) begin
            next_element <= (stream_ok && !last_element) ?
                            next_element + ELEM_W'(1) : '0;
          end
          if (operation == OP_CLEAR) begin
            count        <= '0;
            next_element <= '0;
            for (int k = 0; k < CAPACITY; k++) order[k] <= SLOT_W'(k);
          end
        end
        A_EV_SHIFT: begin
          done <= 1'b0;
          // Close the gap left by the evicted slot; its slot goes to the end.
          for (int k = 0; k < CAPACITY - 1; k++) begin
            if (SLOT_W'(k) >= best_pos) order[k] <= order[k+1];
          end
          order[CAPACITY-1] <= order[best_pos];
          count <= count - CNT_W'(1);
        end
        A_INS_DONE: begin
          count <= count + CNT_W'(1);
          done  <= 1'b1;
        end
        A_RD_DONE: done <= 1'b1;
        default: done <= d_fin;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.act == A_RD_DONE) begin
      key_out         <= key_rd;
      value_out       <= val_rd;
      score_out       <= $signed(sc_rd);
      association_out <= $signed(as_rd);
    end else begin
      key_out         <= '0;
      value_out       <= '0;
      score_out       <= '0;
      association_out <= '0;
    end
    if (accept) begin
      slot_count       <= (operation == OP_CLEAR) ? '0 : count;
      status           <= st_code;
      evicted          <= 1'b0;
      evicted_position <= '0;
    end else if (cmd.act == A_INS_DONE) begin
      slot_count       <= count + CNT_W'(1);
      status           <= ST_OK;
      evicted          <= ev_q;
      evicted_position <= ev_pos_q;
    end else if (cmd.act == A_RD_DONE || d_fin) begin
      slot_count       <= count;
      status           <= ST_OK;
      evicted          <= 1'b0;
      evicted_position <= '0;
    end
  end

endmodule

@@ rtl/scored_slot_store_min_eviction.sv @@
// Ordered store of scored slots with lowest-score eviction and decay.
// Instantiates ssme_ctrl and ssme_dpath; depends on ssme_pkg.
//
// Usage: present a request with start high while busy is low; it is taken
// at that clock edge. Exactly one result follows, shown for one cycle with
// done high; the receiver cannot stall, so it must take it then.
// Set score, set association, clear, plain element writes and all rejected
// requests give done in the cycle after the request; a read passes through
// a read-done state first. The last element of a slot copies the staged
// vector into the slot memory, a read and a write state per word, and clears
// the association row and column, a row and a column state per entry; a
// lowest-score search over all slots comes first when the store is full.
// Decay walks each live score or association entry through read, multiply
// and write-back states in turn.
// busy is high for the whole of a multi-cycle request; a new request may
// be given in the cycle that done is high, whatever the request was.
// Reset (rst, synchronous) empties the store, restores slot order and
// drops any partly staged write; memory contents are left as they are.
module scored_slot_store_min_eviction import ssme_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [2:0]               operation,
  input  logic [SLOT_W-1:0]        slot_index,
  input  logic [SLOT_W-1:0]        other_index,
  input  logic [ELEM_W-1:0]        element_index,
  input  logic [WORD_W-1:0]        key_word,
  input  logic [WORD_W-1:0]        value_word,
  input  logic                     last_element,
  input  logic signed [WORD_W-1:0] amount,
  input  logic [FACT_W-1:0]        decay_factor,
  output logic                     done,
  output logic [WORD_W-1:0]        key_out,
  output logic [WORD_W-1:0]        value_out,
  output logic signed [WORD_W-1:0] score_out,
  output logic signed [WORD_W-1:0] association_out,
  output logic [CNT_W-1:0]         slot_count,
  output logic                     evicted,
  output logic [SLOT_W-1:0]        evicted_position,
  output logic [1:0]               status
);

  cmd_t  cmd;
  stat_t stat;
  logic  ctl_busy;
  logic  take;
  logic  d_fin;
  logic  sweep_q;

  assign take = start && !busy;

  // A decay sweep ends with the controller back in idle before its result is
  // out; mark that first idle cycle so the datapath can post the result.
  always_ff @(posedge clk) begin
    if (rst) sweep_q <= 1'b0;
    else sweep_q <= (cmd.act == A_DS_WR || cmd.act == A_DA_WR);
  end
  assign d_fin = sweep_q && (cmd.act != A_DS_RD) && (cmd.act != A_DA_RD);

  ssme_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (take),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (ctl_busy)
  );

  assign busy = ctl_busy;

  ssme_dpath u_dpath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .d_fin            (d_fin),
    .operation        (operation),
    .slot_index       (slot_index),
    .other_index      (other_index),
    .element_index    (element_index),
    .key_word         (key_word),
    .value_word       (value_word),
    .last_element     (last_element),
    .amount           (amount),
    .decay_factor     (decay_factor),
    .stat             (stat),
    .done             (done),
    .key_out          (key_out),
    .value_out        (value_out),
    .score_out        (score_out),
    .association_out  (association_out),
    .slot_count       (slot_count),
    .evicted          (evicted),
    .evicted_position (evicted_position),
    .status           (status)
  );

endmodule
